// ===== rtl/core/ipf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the ingress port filter.
package ipf_pkg;

   localparam int INTERFACE_COUNT_DEF = 10;
   localparam int PORT_RULES_DEF      = 1024;
   localparam int QUEUE_DEPTH         = 4;
   localparam int ROW_W               = 32;
   localparam int INTF_W              = 6;
   localparam int PORT_W              = 16;

   typedef enum logic [2:0] {
      CAUSE_TRUNCATED = 3'd0,
      CAUSE_NON_IP    = 3'd1,
      CAUSE_ARP       = 3'd2,
      CAUSE_OTHER     = 3'd3,
      CAUSE_NO_RULES  = 3'd4,
      CAUSE_HIGH_PORT = 3'd5,
      CAUSE_ALLOWED   = 3'd6,
      CAUSE_DENIED    = 3'd7
   } cause_type;

   typedef enum logic [1:0] {
      ENTRY_WRITE  = 2'd0,
      ENTRY_LOOKUP = 2'd1,
      ENTRY_DONE   = 2'd2
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type     kind;
      cause_type          cause;
      logic               allow;
      logic [INTF_W-1:0]  intf;
      logic [1:0]         proto;
      logic [PORT_W-1:0]  port;
   } entry_type;

endpackage

// ===== rtl/core/ipf_front.sv =====
`timescale 1ns / 1ps
// Byte parser: walks frame headers and queues one command per frame or in-range rule write.
module ipf_front #(
   parameter int INTERFACE_COUNT = ipf_pkg::INTERFACE_COUNT_DEF,
   parameter int PORT_RULES      = ipf_pkg::PORT_RULES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   input  logic [31:0]         req_interface_req,
   input  logic [1:0]          req_rule_protocol,
   input  logic [9:0]          req_rule_port,
   input  logic                req_rule_allow,
   input  logic                q_ready,
   input  logic                busy,
   output logic                push_valid,
   output ipf_pkg::entry_type  push_entry
);

   localparam int IFW = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1;

   localparam logic OP_PACKET     = 1'b0;
   localparam logic OP_RULE_WRITE = 1'b1;

   localparam logic [15:0] ET_VLAN  = 16'h8100;
   localparam logic [15:0] ET_QINQ  = 16'h88A8;
   localparam logic [15:0] ET_IPV4  = 16'h0800;
   localparam logic [15:0] ET_IPV6  = 16'h86DD;
   localparam logic [15:0] ET_ARP   = 16'h0806;
   localparam logic [15:0] ET_RARP  = 16'h8035;

   localparam logic [15:0] PROTO_ICMP = 16'd1;
   localparam logic [15:0] PROTO_TCP  = 16'd6;
   localparam logic [15:0] PROTO_UDP  = 16'd17;
   localparam logic [15:0] PROTO_SCTP = 16'd132;

   localparam logic [6:0] ETH_HDR_LEN = 7'd14;
   localparam logic [6:0] OFF_MAX     = 7'd127;

   typedef enum logic [2:0] {
      PH_ETH,
      PH_VLAN1,
      PH_VLAN2,
      PH_IPV4,
      PH_IPV6,
      PH_L4,
      PH_READY,
      PH_DECIDED
   } phase_type;

   function automatic logic [6:0] l4_len(input logic [15:0] proto);
      logic [6:0] len;
      len = 7'd0;
      case (proto)
         PROTO_UDP:  len = 7'd8;
         PROTO_TCP:  len = 7'd20;
         PROTO_ICMP: len = 7'd8;
         PROTO_SCTP: len = 7'd12;
         default:    len = 7'd0;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] proto_index(input logic [15:0] proto);
      logic [1:0] idx;
      idx = 2'd3;
      case (proto)
         PROTO_TCP:  idx = 2'd0;
         PROTO_UDP:  idx = 2'd1;
         PROTO_ICMP: idx = 2'd2;
         default:    idx = 2'd3;
      endcase
      return idx;
   endfunction

   phase_type          phase_ff, phase_in;
   logic [6:0]         off_ff, off_in;
   logic [6:0]         he_ff, he_in;
   logic [15:0]        np_ff, np_in;
   logic [15:0]        port_ff, port_in;
   ipf_pkg::cause_type early_ff, early_in;
   logic               intf_ok_ff, intf_ok_in;
   logic [IFW-1:0]     intf_idx_ff, intf_idx_in;

   logic               accept;
   logic               wr_ok;
   logic [15:0]        ether_type;
   logic [6:0]         proto_off;
   logic [6:0]         l4_len_cur;
   logic [6:0]         l4_len_next;
   logic [6:0]         port_hi_off;

   assign req_ready = q_ready && !busy;
   assign accept    = req_valid && req_ready;
   assign wr_ok     = (req_interface_req < 32'(INTERFACE_COUNT))
                   && ({22'd0, req_rule_port} < 32'(PORT_RULES));
   assign ether_type  = np_ff | {8'h00, req_data_byte};
   assign proto_off   = (phase_ff == PH_IPV4) ? (he_ff - 7'd11) : (he_ff - 7'd34);
   assign l4_len_cur  = l4_len(np_ff);
   assign l4_len_next = l4_len(np_in);
   assign port_hi_off = (np_ff == PROTO_ICMP) ? (he_ff - l4_len_cur)
                                              : (he_ff - l4_len_cur + 7'd2);

   always_comb begin
      phase_in    = phase_ff;
      off_in      = off_ff;
      he_in       = he_ff;
      np_in       = np_ff;
      port_in     = port_ff;
      early_in    = early_ff;
      intf_ok_in  = intf_ok_ff;
      intf_idx_in = intf_idx_ff;
      push_valid  = 1'b0;
      push_entry  = '0;
      if (accept && req_operation == OP_RULE_WRITE) begin
         if (wr_ok) begin
            push_valid       = 1'b1;
            push_entry.kind  = ipf_pkg::ENTRY_WRITE;
            push_entry.allow = req_rule_allow;
            push_entry.intf  = ipf_pkg::INTF_W'(req_interface_req[IFW-1:0]);
            push_entry.proto = req_rule_protocol;
            push_entry.port  = ipf_pkg::PORT_W'(req_rule_port);
         end
      end else if (accept && req_operation == OP_PACKET) begin
         if (off_ff == 7'd0) begin
            intf_ok_in  = req_interface_req < 32'(INTERFACE_COUNT);
            intf_idx_in = req_interface_req[IFW-1:0];
         end
         case (phase_ff)
            PH_ETH, PH_VLAN1, PH_VLAN2: begin
               if (off_ff == he_ff - 7'd2) begin
                  np_in = {req_data_byte, 8'h00};
               end else if (off_ff == he_ff - 7'd1) begin
                  np_in = ether_type;
                  if ((ether_type == ET_VLAN || ether_type == ET_QINQ)
                        && phase_ff != PH_VLAN2) begin
                     phase_in = (phase_ff == PH_ETH) ? PH_VLAN1 : PH_VLAN2;
                     he_in    = he_ff + 7'd4;
                  end else if (ether_type == ET_IPV4) begin
                     phase_in = PH_IPV4;
                     he_in    = he_ff + 7'd20;
                  end else if (ether_type == ET_IPV6) begin
                     phase_in = PH_IPV6;
                     he_in    = he_ff + 7'd40;
                  end else if (ether_type == ET_ARP || ether_type == ET_RARP) begin
                     phase_in = PH_DECIDED;
                     early_in = ipf_pkg::CAUSE_ARP;
                  end else begin
                     phase_in = PH_DECIDED;
                     early_in = ipf_pkg::CAUSE_NON_IP;
                  end
               end
            end
            PH_IPV4, PH_IPV6: begin
               if (off_ff == proto_off) begin
                  np_in = {8'h00, req_data_byte};
               end
               if (off_ff == he_ff - 7'd1) begin
                  if (l4_len_next == 7'd0) begin
                     phase_in = PH_DECIDED;
                     early_in = ipf_pkg::CAUSE_OTHER;
                  end else begin
                     phase_in = PH_L4;
                     he_in    = he_ff + l4_len_next;
                  end
               end
            end
            PH_L4: begin
               if (off_ff == port_hi_off) begin
                  port_in = {req_data_byte, 8'h00};
               end else if (off_ff == port_hi_off + 7'd1) begin
                  port_in = port_ff | {8'h00, req_data_byte};
               end
               if (off_ff == he_ff - 7'd1) begin
                  phase_in = PH_READY;
               end
            end
            default: ;
         endcase
         if (req_last) begin
            push_valid       = 1'b1;
            push_entry.kind  = ipf_pkg::ENTRY_DONE;
            push_entry.intf  = ipf_pkg::INTF_W'(intf_idx_in);
            push_entry.proto = proto_index(np_in);
            push_entry.port  = port_in;
            if (phase_in == PH_DECIDED) begin
               push_entry.cause = early_in;
            end else if (phase_in != PH_READY) begin
               push_entry.cause = ipf_pkg::CAUSE_TRUNCATED;
            end else if (!intf_ok_in) begin
               push_entry.cause = ipf_pkg::CAUSE_NO_RULES;
            end else if ({1'b0, port_in} >= 17'(PORT_RULES)) begin
               push_entry.cause = ipf_pkg::CAUSE_HIGH_PORT;
            end else begin
               push_entry.kind = ipf_pkg::ENTRY_LOOKUP;
            end
            phase_in = PH_ETH;
            off_in   = 7'd0;
            he_in    = ETH_HDR_LEN;
            np_in    = 16'd0;
            port_in  = 16'd0;
            early_in = ipf_pkg::CAUSE_TRUNCATED;
         end else if (off_ff != OFF_MAX) begin
            off_in = off_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_ETH;
         off_ff      <= 7'd0;
         he_ff       <= ETH_HDR_LEN;
         np_ff       <= 16'd0;
         port_ff     <= 16'd0;
         early_ff    <= ipf_pkg::CAUSE_TRUNCATED;
         intf_ok_ff  <= 1'b1;
         intf_idx_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         off_ff      <= off_in;
         he_ff       <= he_in;
         np_ff       <= np_in;
         port_ff     <= port_in;
         early_ff    <= early_in;
         intf_ok_ff  <= intf_ok_in;
         intf_idx_ff <= intf_idx_in;
      end
   end

endmodule

// ===== rtl/core/ipf_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the parser and the rule lookup.
module ipf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ipf_pkg::entry_type  push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output ipf_pkg::entry_type  head_entry
);

   localparam int PTR_W = $clog2(ipf_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ipf_pkg::QUEUE_DEPTH + 1);

   ipf_pkg::entry_type store_ff [ipf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(ipf_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/ipf_back.sv =====
`timescale 1ns / 1ps
// Rule memory with reset clearing pass, lookup stage and verdict output register.
module ipf_back #(
   parameter int INTERFACE_COUNT = ipf_pkg::INTERFACE_COUNT_DEF,
   parameter int PORT_RULES      = ipf_pkg::PORT_RULES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ipf_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_verdict,
   output logic [2:0]          rsp_cause
);

   localparam int IFW      = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1;
   localparam int PW       = $clog2(PORT_RULES);
   localparam int MEM_BITS = INTERFACE_COUNT * 4 * PORT_RULES;
   localparam int AW       = $clog2(MEM_BITS);
   localparam int COL_W    = $clog2(ipf_pkg::ROW_W);
   localparam int ROWS     = (MEM_BITS + ipf_pkg::ROW_W - 1) / ipf_pkg::ROW_W;
   localparam int RAW      = $clog2(ROWS);

   logic [ipf_pkg::ROW_W-1:0] mem_ff [ROWS];

   logic                      clear_ff, clear_in;
   logic [RAW-1:0]            clear_row_ff, clear_row_in;
   logic [AW-1:0]             addr;
   logic [RAW-1:0]            row;
   logic [COL_W-1:0]          col;
   logic                      is_write;
   logic                      out_free;
   logic                      s1_free;
   logic                      rd_en;

   logic                      s1_valid_ff, s1_valid_in;
   ipf_pkg::entry_kind_type   s1_kind_ff;
   ipf_pkg::cause_type        s1_cause_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic [ipf_pkg::ROW_W-1:0] rd_row_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   ipf_pkg::cause_type        rsp_cause_ff, rsp_cause_in;
   logic                      rsp_verdict_ff, rsp_verdict_in;

   assign addr = AW'({head_entry.intf[IFW-1:0], head_entry.proto}) * AW'(PORT_RULES)
               + AW'(head_entry.port[PW-1:0]);
   assign row  = addr[COL_W +: RAW];
   assign col  = addr[COL_W-1:0];

   assign is_write = head_entry.kind == ipf_pkg::ENTRY_WRITE;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head_valid && !clear_ff && (is_write || s1_free);
   assign rd_en    = pop && !is_write;
   assign busy     = clear_ff;

   always_comb begin
      clear_in     = clear_ff;
      clear_row_in = clear_row_ff;
      if (clear_ff) begin
         if (clear_row_ff == RAW'(ROWS - 1)) begin
            clear_in = 1'b0;
         end else begin
            clear_row_in = clear_row_ff + 1'b1;
         end
      end
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in   = rsp_valid_ff;
      rsp_cause_in   = rsp_cause_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
         if (s1_kind_ff == ipf_pkg::ENTRY_LOOKUP) begin
            rsp_cause_in = rd_row_ff[s1_col_ff] ? ipf_pkg::CAUSE_ALLOWED
                                                : ipf_pkg::CAUSE_DENIED;
         end else begin
            rsp_cause_in = s1_cause_ff;
         end
         rsp_verdict_in = !(rsp_cause_in == ipf_pkg::CAUSE_TRUNCATED
                         || rsp_cause_in == ipf_pkg::CAUSE_NON_IP
                         || rsp_cause_in == ipf_pkg::CAUSE_DENIED);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_row_ff <= clear_row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cause_ff   <= rsp_cause_in;
      rsp_verdict_ff <= rsp_verdict_in;
      if (rd_en) begin
         s1_kind_ff  <= head_entry.kind;
         s1_cause_ff <= head_entry.cause;
         s1_col_ff   <= col;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem_ff[clear_row_ff] <= '0;
      end else if (pop && is_write) begin
         mem_ff[row][col] <= head_entry.allow;
      end
      if (rd_en) begin
         rd_row_ff <= mem_ff[row];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_cause   = rsp_cause_ff;

   a_queue_empty_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clear_ff |-> !head_valid)
      else $error("command queued during rule memory clearing pass");

   a_clear_runs_once: assert property (
      @(posedge clock) disable iff (reset) !clear_ff |=> !clear_ff)
      else $error("rule memory clearing pass restarted");

   a_stalled_lookup_holds: assert property (
      @(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_col_ff) && $stable(rd_row_ff))
      else $error("stalled lookup stage lost its read data");

endmodule

// ===== rtl/core/ingress_port_filter_core.sv =====
`timescale 1ns / 1ps
// Path: a verdict passes the queue, the lookup stage and the verdict output register.
// Throughput: one byte or rule write per cycle; the parser, queue and lookup stage
// each stall on their own, and the rule memory port takes one access per cycle.
// Reset: after reset the rule memory is cleared to deny, one 32-bit row per cycle,
// ceil(INTERFACE_COUNT*4*PORT_RULES/32) rows (1280 by default); req_ready stays low.
module ingress_port_filter_core #(
   parameter int INTERFACE_COUNT = ipf_pkg::INTERFACE_COUNT_DEF,
   parameter int PORT_RULES      = ipf_pkg::PORT_RULES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic [31:0] req_interface_req,
   input  logic [1:0]  req_rule_protocol,
   input  logic [9:0]  req_rule_port,
   input  logic        req_rule_allow,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_verdict,
   output logic [2:0]  rsp_cause
);

   logic               q_ready;
   logic               busy;
   logic               push_valid;
   ipf_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   ipf_pkg::entry_type head_entry;

   ipf_front #(
      .INTERFACE_COUNT (INTERFACE_COUNT),
      .PORT_RULES      (PORT_RULES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .req_interface_req (req_interface_req),
      .req_rule_protocol (req_rule_protocol),
      .req_rule_port     (req_rule_port),
      .req_rule_allow    (req_rule_allow),
      .q_ready           (q_ready),
      .busy              (busy),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   ipf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ipf_back #(
      .INTERFACE_COUNT (INTERFACE_COUNT),
      .PORT_RULES      (PORT_RULES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .rsp_cause   (rsp_cause)
   );

endmodule

// ===== dv/ingress_port_filter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ingress_port_filter_core: frames, rule writes and verdicts.
module ingress_port_filter_core_tb;

   localparam int INTF_COUNT = ipf_pkg::INTERFACE_COUNT_DEF;
   localparam int PORT_LIMIT = ipf_pkg::PORT_RULES_DEF;
   localparam int ACL_BITS   = INTF_COUNT * 4 * PORT_LIMIT;
   localparam int OFFSET_MAX = 127;

   localparam bit OP_BYTE = 1'b0;
   localparam bit OP_RULE = 1'b1;

   localparam logic [1:0] RP_TCP  = 2'd0;
   localparam logic [1:0] RP_UDP  = 2'd1;
   localparam logic [1:0] RP_ICMP = 2'd2;
   localparam logic [1:0] RP_SCTP = 2'd3;

   localparam logic [15:0] ET_IPV4  = 16'h0800;
   localparam logic [15:0] ET_IPV6  = 16'h86DD;
   localparam logic [15:0] ET_ARP   = 16'h0806;
   localparam logic [15:0] ET_RARP  = 16'h8035;
   localparam logic [15:0] ET_CVLAN = 16'h8100;
   localparam logic [15:0] ET_SVLAN = 16'h88A8;
   localparam logic [15:0] ET_OTHER = 16'h1234;

   localparam logic [7:0] IP_ICMP = 8'd1;
   localparam logic [7:0] IP_TCP  = 8'd6;
   localparam logic [7:0] IP_UDP  = 8'd17;
   localparam logic [7:0] IP_GRE  = 8'd47;
   localparam logic [7:0] IP_SCTP = 8'd132;

   localparam int ETH_HDR  = 14;
   localparam int TAG_LEN  = 4;
   localparam int IPV4_HDR = 20;
   localparam int IPV6_HDR = 40;
   localparam int UDP_HDR  = 8;
   localparam int TCP_HDR  = 20;
   localparam int ICMP_HDR = 8;
   localparam int SCTP_HDR = 12;
   localparam int IPV4_PROTO_AT = 9;
   localparam int IPV6_PROTO_AT = 6;

   localparam int ITEM_TARGET  = 1200;
   localparam int FRAME_TARGET = 7;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum logic [2:0] {
      ST_ETH, ST_VLAN1, ST_VLAN2, ST_IPV4, ST_IPV6, ST_L4, ST_READY, ST_DECIDED
   } parse_stage_type;

   typedef struct packed {
      logic               pass_frame;
      ipf_pkg::cause_type cause;
   } verdict_type;

   function automatic int unsigned l4_header_len(logic [7:0] proto);
      case (proto)
         IP_UDP:  return UDP_HDR;
         IP_TCP:  return TCP_HDR;
         IP_ICMP: return ICMP_HDR;
         IP_SCTP: return SCTP_HDR;
         default: return 0;
      endcase
   endfunction

   function automatic logic [1:0] rule_proto(logic [7:0] proto);
      case (proto)
         IP_TCP:  return RP_TCP;
         IP_UDP:  return RP_UDP;
         IP_ICMP: return RP_ICMP;
         default: return RP_SCTP;
      endcase
   endfunction

   class verdict_scoreboard;
      bit                 allow_bits[ACL_BITS];
      int unsigned        offset;
      int unsigned        hdr_end;
      parse_stage_type    stage;
      logic [15:0]        ethertype;
      logic [15:0]        dport;
      logic [7:0]         ip_proto;
      logic [31:0]        frame_intf;
      ipf_pkg::cause_type early_cause;
      verdict_type        expected_q[$];
      int unsigned        mismatches;

      function new();
         frame_intf  = '0;
         mismatches  = 0;
         early_cause = ipf_pkg::CAUSE_TRUNCATED;
         restart();
      endfunction

      function void restart();
         offset    = 0;
         stage     = ST_ETH;
         ethertype = '0;
         ip_proto  = '0;
         dport     = '0;
         hdr_end   = ETH_HDR;
      endfunction

      function void decide(ipf_pkg::cause_type c);
         early_cause = c;
         stage       = ST_DECIDED;
      endfunction

      function void take_ethertype(bit vlan_ok, parse_stage_type vlan_next);
         if ((ethertype == ET_CVLAN || ethertype == ET_SVLAN) && vlan_ok) begin
            stage = vlan_next;
            hdr_end += TAG_LEN;
         end else if (ethertype == ET_IPV4) begin
            stage = ST_IPV4;
            hdr_end += IPV4_HDR;
         end else if (ethertype == ET_IPV6) begin
            stage = ST_IPV6;
            hdr_end += IPV6_HDR;
         end else if (ethertype == ET_ARP || ethertype == ET_RARP) begin
            decide(ipf_pkg::CAUSE_ARP);
         end else begin
            decide(ipf_pkg::CAUSE_NON_IP);
         end
      endfunction

      function void parse(logic [7:0] b);
         int unsigned base;
         case (stage)
            ST_ETH, ST_VLAN1, ST_VLAN2: begin
               if (offset == hdr_end - 2) begin
                  ethertype = {b, 8'h00};
               end else if (offset == hdr_end - 1) begin
                  ethertype[7:0] = b;
                  take_ethertype(stage != ST_VLAN2, (stage == ST_ETH) ? ST_VLAN1 : ST_VLAN2);
               end
            end
            ST_IPV4, ST_IPV6: begin
               base = hdr_end - ((stage == ST_IPV4) ? IPV4_HDR : IPV6_HDR);
               if (offset == base + ((stage == ST_IPV4) ? IPV4_PROTO_AT : IPV6_PROTO_AT))
                  ip_proto = b;
               if (offset == hdr_end - 1) begin
                  if (l4_header_len(ip_proto) == 0) begin
                     decide(ipf_pkg::CAUSE_OTHER);
                  end else begin
                     stage = ST_L4;
                     hdr_end += l4_header_len(ip_proto);
                  end
               end
            end
            ST_L4: begin
               base = hdr_end - l4_header_len(ip_proto);
               if (ip_proto == IP_ICMP) begin
                  if (offset == base) dport = {b, 8'h00};
                  else if (offset == base + 1) dport[7:0] = b;
               end else begin
                  if (offset == base + 2) dport = {b, 8'h00};
                  else if (offset == base + 3) dport[7:0] = b;
               end
               if (offset == hdr_end - 1) stage = ST_READY;
            end
            default: ;
         endcase
      endfunction

      function ipf_pkg::cause_type frame_cause();
         int unsigned idx;
         if (stage == ST_DECIDED) return early_cause;
         if (stage != ST_READY) return ipf_pkg::CAUSE_TRUNCATED;
         if (frame_intf >= INTF_COUNT) return ipf_pkg::CAUSE_NO_RULES;
         if (dport >= PORT_LIMIT) return ipf_pkg::CAUSE_HIGH_PORT;
         idx = (int'(frame_intf) * 4 + rule_proto(ip_proto)) * PORT_LIMIT + dport;
         if (allow_bits[idx]) return ipf_pkg::CAUSE_ALLOWED;
         return ipf_pkg::CAUSE_DENIED;
      endfunction

      function void note_input(bit op, logic [7:0] b, bit last, logic [31:0] intf,
                               logic [1:0] rproto, logic [9:0] rport, bit allow);
         verdict_type e;
         int unsigned idx;
         if (op == OP_RULE) begin
            if (intf < INTF_COUNT && rport < PORT_LIMIT) begin
               idx = (int'(intf) * 4 + rproto) * PORT_LIMIT + rport;
               allow_bits[idx] = allow;
            end
            return;
         end
         if (offset == 0) frame_intf = intf;
         parse(b);
         if (last) begin
            e.cause      = frame_cause();
            e.pass_frame = !(e.cause inside {ipf_pkg::CAUSE_TRUNCATED, ipf_pkg::CAUSE_NON_IP,
                                             ipf_pkg::CAUSE_DENIED});
            expected_q.push_back(e);
            restart();
         end else if (offset < OFFSET_MAX) begin
            offset++;
         end
      endfunction

      function void check_result(logic pass_frame, logic [2:0] cause);
         verdict_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, actual verdict %0d cause %0d",
                     $time, pass_frame, cause);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         if (pass_frame !== e.pass_frame) begin
            $display("%0t: verdict mismatch, expected %0d actual %0d",
                     $time, e.pass_frame, pass_frame);
            mismatches++;
         end
         if (cause !== e.cause) begin
            $display("%0t: cause mismatch, expected %0d actual %0d", $time, e.cause, cause);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic        req_operation     = OP_BYTE;
   logic [7:0]  req_data_byte     = '0;
   logic        req_last          = 1'b0;
   logic [31:0] req_interface_req = '0;
   logic [1:0]  req_rule_protocol = RP_TCP;
   logic [9:0]  req_rule_port     = '0;
   logic        req_rule_allow    = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_verdict;
   logic [2:0]  rsp_cause;

   verdict_scoreboard sb = new();
   bit          steady       = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned items_sent   = 0;
   int unsigned stall_count  = 0;
   logic [7:0]  frame_bytes[$];

   ingress_port_filter_core #(
      .INTERFACE_COUNT(INTF_COUNT),
      .PORT_RULES(PORT_LIMIT)
   ) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_verdict, rsp_cause);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= steady || ($urandom_range(99) >= 21);
      end
   end

   task automatic send_item(bit op, logic [7:0] b, bit last, logic [31:0] intf,
                            logic [1:0] rproto, logic [9:0] rport, bit allow);
      while (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_data_byte     <= b;
      req_last          <= last;
      req_interface_req <= intf;
      req_rule_protocol <= rproto;
      req_rule_port     <= rport;
      req_rule_allow    <= allow;
      do @(posedge clock); while (!req_ready);
      sb.note_input(op, b, last, intf, rproto, rport, allow);
      items_sent++;
   endtask

   task automatic send_rule(logic [31:0] intf, logic [1:0] rproto, logic [9:0] rport, bit allow);
      send_item(OP_RULE, 8'($urandom), 1'($urandom), intf, rproto, rport, allow);
   endtask

   function automatic logic [31:0] pick_intf();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(INTF_COUNT - 1);
      if (r < 85) return $urandom_range(INTF_COUNT + 5, INTF_COUNT);
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_port();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 16'($urandom_range(15));
      if (r < 70) return 16'($urandom_range(PORT_LIMIT - 1));
      if (r < 75) return 16'(PORT_LIMIT - 1);
      if (r < 80) return 16'(PORT_LIMIT);
      if (r < 85) return 16'hFFFF;
      return 16'($urandom_range(65535, PORT_LIMIT));
   endfunction

   task automatic random_rule();
      send_rule(pick_intf(), 2'($urandom),
                ($urandom_range(99) < 70) ? 10'($urandom_range(15)) : 10'($urandom),
                1'($urandom));
   endtask

   function automatic void et_push(logic [15:0] et);
      frame_bytes.push_back(et[15:8]);
      frame_bytes.push_back(et[7:0]);
   endfunction

   function automatic void build_frame(int vlans, logic [15:0] et, logic [7:0] proto,
                                       logic [15:0] port, int extra, int cut);
      int unsigned l4_len;
      frame_bytes.delete();
      repeat (12) frame_bytes.push_back(8'($urandom));
      repeat (vlans) begin
         et_push($urandom_range(1) ? ET_CVLAN : ET_SVLAN);
         repeat (2) frame_bytes.push_back(8'($urandom));
      end
      et_push(et);
      if (et == ET_IPV4 || et == ET_IPV6) begin
         for (int k = 0; k < ((et == ET_IPV4) ? IPV4_HDR : IPV6_HDR); k++) begin
            if (k == ((et == ET_IPV4) ? IPV4_PROTO_AT : IPV6_PROTO_AT))
               frame_bytes.push_back(proto);
            else
               frame_bytes.push_back(8'($urandom));
         end
         l4_len = l4_header_len(proto);
         for (int k = 0; k < l4_len; k++) begin
            if (k == ((proto == IP_ICMP) ? 0 : 2)) frame_bytes.push_back(port[15:8]);
            else if (k == ((proto == IP_ICMP) ? 1 : 3)) frame_bytes.push_back(port[7:0]);
            else frame_bytes.push_back(8'($urandom));
         end
      end
      repeat (extra) frame_bytes.push_back(8'($urandom));
      if (cut > 0 && cut < frame_bytes.size()) frame_bytes = frame_bytes[0:cut-1];
   endfunction

   task automatic send_frame(logic [31:0] intf);
      foreach (frame_bytes[i]) begin
         if ($urandom_range(99) < 3) random_rule();
         send_item(OP_BYTE, frame_bytes[i], i == frame_bytes.size() - 1,
                   (i == 0 || $urandom_range(1)) ? intf : $urandom,
                   2'($urandom), 10'($urandom), 1'($urandom));
      end
   endtask

   task automatic random_frame();
      int          kind;
      int          vlans;
      logic [15:0] et;
      logic [7:0]  proto;
      kind  = $urandom_range(99);
      vlans = $urandom_range(2);
      et    = $urandom_range(1) ? ET_IPV4 : ET_IPV6;
      case ($urandom_range(3))
         0:       proto = IP_TCP;
         1:       proto = IP_UDP;
         2:       proto = IP_ICMP;
         default: proto = IP_SCTP;
      endcase
      if (kind < 10) proto = 8'($urandom);
      else if (kind < 18) et = $urandom_range(1) ? ET_ARP : ET_RARP;
      else if (kind < 25) et = 16'($urandom);
      else if (kind < 30) vlans = 3;
      build_frame(vlans, et, proto, pick_port(),
                  ($urandom_range(99) < 5) ? $urandom_range(80, 40) : $urandom_range(6),
                  ($urandom_range(99) < 15) ? $urandom_range(70, 1) : 0);
      send_frame(pick_intf());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_rule(0, RP_UDP, 10'd53, 1'b1);
      send_rule(INTF_COUNT - 1, RP_TCP, 10'(PORT_LIMIT - 1), 1'b1);
      send_rule(INTF_COUNT, RP_UDP, 10'd53, 1'b1);
      send_rule(3, RP_ICMP, 10'h301, 1'b1);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 0, 0);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd54, 4, 0);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 0, 0);
      send_frame(INTF_COUNT);
      build_frame(1, ET_IPV4, IP_UDP, 16'd53, 0, 0);
      send_frame(32'hFFFF_FFFF);
      build_frame(0, ET_IPV4, IP_UDP, 16'(PORT_LIMIT), 0, 0);
      send_frame(0);
      build_frame(0, ET_IPV6, IP_UDP, 16'hFFFF, 0, 0);
      send_frame(0);
      build_frame(2, ET_IPV6, IP_TCP, 16'(PORT_LIMIT - 1), 2, 0);
      send_frame(INTF_COUNT - 1);
      build_frame(0, ET_IPV6, IP_ICMP, 16'h0301, 0, 0);
      send_frame(3);
      build_frame(1, ET_IPV4, IP_SCTP, 16'd0, 0, 0);
      send_frame(0);
      build_frame(0, ET_ARP, IP_UDP, 16'd0, 3, 0);
      send_frame(1);
      build_frame(2, ET_RARP, IP_UDP, 16'd0, 0, 0);
      send_frame(2);
      build_frame(0, ET_OTHER, IP_UDP, 16'd0, 0, 0);
      send_frame(0);
      build_frame(3, ET_IPV4, IP_UDP, 16'd53, 0, 0);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_GRE, 16'd0, 5, 0);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 0, 1);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 0, 20);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 0, ETH_HDR + IPV4_HDR + UDP_HDR - 1);
      send_frame(0);
      send_rule(0, RP_UDP, 10'd53, 1'b0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 0, 0);
      send_frame(0);
      build_frame(0, ET_IPV4, IP_UDP, 16'd53, 80, 0);
      send_frame(0);
      drain();

      n = 0;
      while (items_sent < ITEM_TARGET || n < FRAME_TARGET) begin
         steady = (n >= 2 && n < 6);
         if (n == 1) begin
            hold_request = 1'b1;
            repeat (30) begin
               build_frame(0, ET_IPV4, IP_UDP, 16'd0, 0, $urandom_range(3, 1));
               send_frame(pick_intf());
            end
         end
         if (n == 6) drain();
         if ($urandom_range(99) < 25) repeat ($urandom_range(4, 1)) random_rule();
         random_frame();
         n++;
      end
      steady = 1'b0;
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
